### rtl/core/indexed_min_heap_queue_top_defines.svh
// Assertion macros shared by the indexed min-heap queue RTL.
`ifndef INDEXED_MIN_HEAP_QUEUE_TOP_DEFINES_SVH
`define INDEXED_MIN_HEAP_QUEUE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IMHQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IMHQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/imhq_pkg.sv
// Shared constants and codes of the indexed min-heap queue.
package imhq_pkg;

  // Default sizing.
  localparam int CAPACITY_DEF = 256;
  localparam int KEY_BITS_DEF = 32;

  // Fixed port field widths.
  localparam int OP_W   = 2;
  localparam int VTX_W  = 9;
  localparam int PRI_W  = 32;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 9;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [OP_W-1:0] OP_EXTRACT = 2'd1;
  localparam logic [OP_W-1:0] OP_CHANGE  = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd2;
  localparam logic [STAT_W-1:0] ST_DUP    = 3'd3;
  localparam logic [STAT_W-1:0] ST_ABSENT = 3'd4;

endpackage

### rtl/core/indexed_min_heap_queue_top.sv
// Top level of the indexed min-heap priority queue with decrease/increase key.
// Indexed binary min-heap: insert a vertex with a key, extract the minimum, or
// change a queued vertex's key; each word in gives exactly one result word with
// a status, the extracted vertex and key, and the entry count. The heap and the
// vertex-to-position table live in two single-port-read RAMs, and one sequencer
// walks the tree with one key comparator. Going up, each level reads the parent,
// then compares and moves; going down, it reads the left child, then the right
// child, then compares and moves. A new word is taken only once the result of
// the last one has entered the output register, which holds while the receiver
// does not take it. After reset the position table is cleared, one entry a
// cycle, before the first word is taken.
`include "indexed_min_heap_queue_top_defines.svh"

module indexed_min_heap_queue_top #(
  parameter int CAPACITY = imhq_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = imhq_pkg::KEY_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [imhq_pkg::OP_W-1:0]   in_opcode,
  input  logic [imhq_pkg::VTX_W-1:0]  in_vertex,
  input  logic [imhq_pkg::PRI_W-1:0]  in_priority_req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [imhq_pkg::STAT_W-1:0] out_status,
  output logic [imhq_pkg::VTX_W-1:0]  out_vertex,
  output logic [imhq_pkg::PRI_W-1:0]  out_priority,
  output logic [imhq_pkg::CNT_W-1:0]  out_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int VW = imhq_pkg::VTX_W;
  localparam int HW = VW + KEY_BITS;

  typedef enum logic [12:0] {
    S_CLEAR    = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_POS      = 13'b0000000000100,
    S_UP       = 13'b0000000001000,
    S_UP_CMP   = 13'b0000000010000,
    S_EXT_TOP  = 13'b0000000100000,
    S_EXT_LAST = 13'b0000001000000,
    S_DN       = 13'b0000010000000,
    S_DN_L     = 13'b0000100000000,
    S_DN_R     = 13'b0001000000000,
    S_DN_MV    = 13'b0010000000000,
    S_PLACE    = 13'b0100000000000,
    S_DONE     = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [imhq_pkg::OP_W-1:0]   op_r, op_nxt;
  logic [VW-1:0]               cur_vtx_r, cur_vtx_nxt;
  logic [KEY_BITS-1:0]         cur_key_r, cur_key_nxt;
  logic [PW-1:0]               hole_r, hole_nxt;
  logic [PW-1:0]               count_r, count_nxt;
  logic [imhq_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [VW-1:0]               res_vtx_r, res_vtx_nxt;
  logic [KEY_BITS-1:0]         res_key_r, res_key_nxt;
  logic [VW-1:0]               cand_vtx_r, cand_vtx_nxt;
  logic [KEY_BITS-1:0]         cand_key_r, cand_key_nxt;
  logic [PW-1:0]               cand_idx_r, cand_idx_nxt;
  logic                        cand_child_r, cand_child_nxt;
  logic [AW-1:0]               clr_idx_r, clr_idx_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [imhq_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [VW-1:0]               out_vertex_r, out_vertex_nxt;
  logic [imhq_pkg::PRI_W-1:0]  out_priority_r, out_priority_nxt;
  logic [imhq_pkg::CNT_W-1:0]  out_count_r, out_count_nxt;

  // RAM ports.
  logic          hp_we, ps_we;
  logic [AW-1:0] hp_waddr, hp_raddr, ps_waddr, ps_raddr;
  logic [HW-1:0] hp_wdata, hp_rdata;
  logic [PW-1:0] ps_wdata, ps_rdata;

  // Fields of the heap word read back.
  logic [VW-1:0]       rd_vtx;
  logic [KEY_BITS-1:0] rd_key;
  assign rd_vtx = hp_rdata[HW-1 -: VW];
  assign rd_key = hp_rdata[KEY_BITS-1:0];

  // Child indices of the current hole.
  logic [PW:0] l_idx, r_idx;
  assign l_idx = {hole_r, 1'b0};
  assign r_idx = {hole_r, 1'b1};

  // Input vertex checks.
  logic          in_vtx_ok;
  logic [AW-1:0] in_vidx;
  assign in_vtx_ok = (in_vertex != '0) && (int'(in_vertex) <= CAPACITY);
  assign in_vidx   = AW'(in_vertex - VW'(1));

  // The one shared key comparator.
  logic [KEY_BITS-1:0] lt_a, lt_b;
  logic                lt;
  always_comb begin
    case (state_r)
      S_UP_CMP: begin
        lt_a = cur_key_r;
        lt_b = rd_key;
      end
      S_DN_R: begin
        lt_a = rd_key;
        lt_b = cand_key_r;
      end
      default: begin
        lt_a = rd_key;
        lt_b = cur_key_r;
      end
    endcase
  end
  assign lt = lt_a < lt_b;

  // Sequencer.
  always_comb begin
    state_nxt        = state_r;
    op_nxt           = op_r;
    cur_vtx_nxt      = cur_vtx_r;
    cur_key_nxt      = cur_key_r;
    hole_nxt         = hole_r;
    count_nxt        = count_r;
    status_nxt       = status_r;
    res_vtx_nxt      = res_vtx_r;
    res_key_nxt      = res_key_r;
    cand_vtx_nxt     = cand_vtx_r;
    cand_key_nxt     = cand_key_r;
    cand_idx_nxt     = cand_idx_r;
    cand_child_nxt   = cand_child_r;
    clr_idx_nxt      = clr_idx_r;
    out_valid_nxt    = out_valid_r;
    out_status_nxt   = out_status_r;
    out_vertex_nxt   = out_vertex_r;
    out_priority_nxt = out_priority_r;
    out_count_nxt    = out_count_r;
    hp_we            = 1'b0;
    hp_waddr         = '0;
    hp_wdata         = '0;
    hp_raddr         = '0;
    ps_we            = 1'b0;
    ps_waddr         = '0;
    ps_wdata         = '0;
    ps_raddr         = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        ps_we       = 1'b1;
        ps_waddr    = clr_idx_r;
        clr_idx_nxt = clr_idx_r + AW'(1);
        if (clr_idx_r == AW'(CAPACITY - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_opcode;
          cur_vtx_nxt = in_vertex;
          cur_key_nxt = KEY_BITS'(in_priority_req);
          status_nxt  = imhq_pkg::ST_OK;
          res_vtx_nxt = '0;
          res_key_nxt = '0;
          ps_raddr    = in_vidx;
          case (in_opcode)
            imhq_pkg::OP_INSERT, imhq_pkg::OP_CHANGE: begin
              if (in_vtx_ok) begin
                state_nxt = S_POS;
              end else begin
                status_nxt = imhq_pkg::ST_ABSENT;
                state_nxt  = S_DONE;
              end
            end
            imhq_pkg::OP_EXTRACT: begin
              if (count_r == '0) begin
                status_nxt = imhq_pkg::ST_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_EXT_TOP;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      // Position of the vertex is back from the table.
      S_POS: begin
        if (op_r == imhq_pkg::OP_INSERT) begin
          if (ps_rdata != '0) begin
            status_nxt = imhq_pkg::ST_DUP;
            state_nxt  = S_DONE;
          end else if (count_r == PW'(CAPACITY)) begin
            status_nxt = imhq_pkg::ST_FULL;
            state_nxt  = S_DONE;
          end else begin
            count_nxt = count_r + PW'(1);
            hole_nxt  = count_r + PW'(1);
            state_nxt = S_UP;
          end
        end else begin
          if (ps_rdata == '0 || ps_rdata > count_r) begin
            status_nxt = imhq_pkg::ST_ABSENT;
            state_nxt  = S_DONE;
          end else begin
            hole_nxt  = ps_rdata;
            state_nxt = S_UP;
          end
        end
      end
      // Sift up: fetch the parent of the hole.
      S_UP: begin
        if (hole_r == PW'(1)) begin
          state_nxt = S_DN;
        end else begin
          hp_raddr  = AW'((hole_r >> 1) - PW'(1));
          state_nxt = S_UP_CMP;
        end
      end
      // Move the parent down into the hole when the key is smaller.
      S_UP_CMP: begin
        if (lt) begin
          hp_we     = 1'b1;
          hp_waddr  = AW'(hole_r - PW'(1));
          hp_wdata  = hp_rdata;
          ps_we     = 1'b1;
          ps_waddr  = AW'(rd_vtx - VW'(1));
          ps_wdata  = hole_r;
          hole_nxt  = hole_r >> 1;
          state_nxt = S_UP;
        end else begin
          state_nxt = S_DN;
        end
      end
      // Root is back: record it, then fetch the last entry.
      S_EXT_TOP: begin
        res_vtx_nxt = rd_vtx;
        res_key_nxt = rd_key;
        ps_we       = 1'b1;
        ps_waddr    = AW'(rd_vtx - VW'(1));
        ps_wdata    = '0;
        count_nxt   = count_r - PW'(1);
        if (count_r == PW'(1)) begin
          state_nxt = S_DONE;
        end else begin
          hp_raddr  = AW'(count_r - PW'(1));
          state_nxt = S_EXT_LAST;
        end
      end
      S_EXT_LAST: begin
        cur_vtx_nxt = rd_vtx;
        cur_key_nxt = rd_key;
        hole_nxt    = PW'(1);
        state_nxt   = S_DN;
      end
      // Sift down: fetch the left child if there is one.
      S_DN: begin
        if (l_idx > {1'b0, count_r}) begin
          state_nxt = S_PLACE;
        end else begin
          hp_raddr  = AW'(l_idx - (PW+1)'(1));
          state_nxt = S_DN_L;
        end
      end
      S_DN_L: begin
        cand_child_nxt = lt;
        cand_vtx_nxt   = lt ? rd_vtx : cur_vtx_r;
        cand_key_nxt   = lt ? rd_key : cur_key_r;
        cand_idx_nxt   = PW'(l_idx);
        if (r_idx <= {1'b0, count_r}) begin
          hp_raddr  = AW'(l_idx);
          state_nxt = S_DN_R;
        end else begin
          state_nxt = S_DN_MV;
        end
      end
      S_DN_R: begin
        if (lt) begin
          cand_child_nxt = 1'b1;
          cand_vtx_nxt   = rd_vtx;
          cand_key_nxt   = rd_key;
          cand_idx_nxt   = PW'(r_idx);
        end
        state_nxt = S_DN_MV;
      end
      // Move the smaller child up into the hole, or stop.
      S_DN_MV: begin
        if (cand_child_r) begin
          hp_we     = 1'b1;
          hp_waddr  = AW'(hole_r - PW'(1));
          hp_wdata  = {cand_vtx_r, cand_key_r};
          ps_we     = 1'b1;
          ps_waddr  = AW'(cand_vtx_r - VW'(1));
          ps_wdata  = hole_r;
          hole_nxt  = cand_idx_r;
          state_nxt = S_DN;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      // Drop the moving entry into its final slot.
      S_PLACE: begin
        hp_we     = 1'b1;
        hp_waddr  = AW'(hole_r - PW'(1));
        hp_wdata  = {cur_vtx_r, cur_key_r};
        ps_we     = 1'b1;
        ps_waddr  = AW'(cur_vtx_r - VW'(1));
        ps_wdata  = hole_r;
        state_nxt = S_DONE;
      end
      // Hand the result word to the output register.
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_status_nxt   = status_r;
          out_vertex_nxt   = res_vtx_r;
          out_priority_nxt = imhq_pkg::PRI_W'(res_key_r);
          out_count_nxt    = imhq_pkg::CNT_W'(count_r);
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r           <= op_nxt;
    cur_vtx_r      <= cur_vtx_nxt;
    cur_key_r      <= cur_key_nxt;
    hole_r         <= hole_nxt;
    status_r       <= status_nxt;
    res_vtx_r      <= res_vtx_nxt;
    res_key_r      <= res_key_nxt;
    cand_vtx_r     <= cand_vtx_nxt;
    cand_key_r     <= cand_key_nxt;
    cand_idx_r     <= cand_idx_nxt;
    cand_child_r   <= cand_child_nxt;
    out_status_r   <= out_status_nxt;
    out_vertex_r   <= out_vertex_nxt;
    out_priority_r <= out_priority_nxt;
    out_count_r    <= out_count_nxt;
  end

  // Heap array: vertex and key per slot.
  imhq_ram #(
    .WIDTH (HW),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk   (clk),
    .we    (hp_we),
    .waddr (hp_waddr),
    .wdata (hp_wdata),
    .raddr (hp_raddr),
    .rdata (hp_rdata)
  );

  // Vertex-to-position table; zero means absent.
  imhq_ram #(
    .WIDTH (PW),
    .DEPTH (CAPACITY)
  ) u_pos_ram (
    .clk   (clk),
    .we    (ps_we),
    .waddr (ps_waddr),
    .wdata (ps_wdata),
    .raddr (ps_raddr),
    .rdata (ps_rdata)
  );

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_vertex   = out_vertex_r;
  assign out_priority = out_priority_r;
  assign out_count    = out_count_r;

  // Checks on the sequencer.
  `IMHQ_ASSERT_SAME(a_count_bound, 1'b1, count_r <= PW'(CAPACITY), "count above capacity")
  `IMHQ_ASSERT_SAME(a_heap_wr_state, hp_we, state_r == S_UP_CMP || state_r == S_DN_MV || state_r == S_PLACE, "heap write outside sift")
  `IMHQ_ASSERT_NEXT(a_extract_dec, state_r == S_EXT_TOP, count_r == PW'($past(count_r) - PW'(1)), "extract did not drop count")
  `IMHQ_ASSERT_SAME(a_hole_nonzero, state_r == S_UP || state_r == S_DN || state_r == S_PLACE, hole_r != '0, "hole index zero")

endmodule

### rtl/core/imhq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module imhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
